>>> sv/bsb_pkg.sv
// shared constants, types and state codes of the separable box blur
package bsb_pkg;

	// default sizes of the row store and the window
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_MAX_RADIUS = 7;

	// fixed field widths of the ports
	localparam int CHAN_W      = 8;
	localparam int OUT_CHAN_W  = 16;
	localparam int COORD_OUT_W = 10;
	localparam int RADIUS_W    = 3;
	localparam int SIZE_W      = 11;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 11;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	// register values after reset
	localparam logic [RADIUS_W-1:0] RST_RADIUS = 3'd5;
	localparam logic [SIZE_W-1:0]   RST_WIDTH  = 11'd1024;
	localparam logic [SIZE_W-1:0]   RST_HEIGHT = 11'd1024;

	// item function codes
	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_DRAIN = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_READ,
		ST_LAST,
		ST_DSTART,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

>>> sv/bsb_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module bsb_div #(
	parameter int NUM_W = 26,
	parameter int DEN_W = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quot
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W:0]   rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W+1:0] rem_sh;
	logic             fits;

	// shift in next dividend bit and try subtracting
	always_comb begin
		rem_sh = {rem_q, quo_q[NUM_W-1]};
		fits   = rem_sh >= {2'b00, den_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? (DEN_W+1)'(rem_sh - {2'b00, den_q}) : rem_sh[DEN_W:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;

endmodule

>>> sv/separable_box_blur_clamped.sv
// Box blur with clamped edges over an RGB raster stream, 8.8 results rounded half up.
// After each transaction the block checks whether an output is ready; when one is, it
// then sweeps the (2R+1)^2 window taps through the single read port of the row store,
// one tap per cycle, and divides the three sums on three bit-serial dividers of NUM_W
// (26 by default) quotient bits. Pixels sit in a row store of 2*MAX_RADIUS+2 rows;
// it is not cleared after reset and a frame must be sent in full before its blurred
// rows can be relied on. A write to the radius, width or height register restarts
// the frame. A finished result waits in the output register while the next
// transaction is taken.
module separable_box_blur_clamped #(
	parameter int MAX_WIDTH  = bsb_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bsb_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_RADIUS = bsb_pkg::DEF_MAX_RADIUS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bsb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bsb_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              func,
	input  logic [bsb_pkg::CHAN_W-1:0]        red_in,
	input  logic [bsb_pkg::CHAN_W-1:0]        green_in,
	input  logic [bsb_pkg::CHAN_W-1:0]        blue_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [bsb_pkg::OUT_CHAN_W-1:0]    red_out,
	output logic [bsb_pkg::OUT_CHAN_W-1:0]    green_out,
	output logic [bsb_pkg::OUT_CHAN_W-1:0]    blue_out,
	output logic [bsb_pkg::COORD_OUT_W-1:0]   out_x,
	output logic [bsb_pkg::COORD_OUT_W-1:0]   out_y,
	output logic                              frame_last
);
	import bsb_pkg::*;

	localparam int XW    = $clog2(MAX_WIDTH + 1);
	localparam int YW    = $clog2(MAX_HEIGHT + 1);
	localparam int RW    = $clog2(MAX_RADIUS + 1);
	localparam int TW    = $clog2(2 * MAX_RADIUS + 1);
	localparam int SLOTS = 2 * MAX_RADIUS + 2;
	localparam int SW    = $clog2(SLOTS);
	localparam int DEPTH = SLOTS * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int XSW   = ((XW > RW + 1) ? XW : RW + 1) + 2;
	localparam int YSW   = ((YW > RW + 1) ? YW : RW + 1) + 2;
	localparam int DMAX  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
	localparam int SUM_W = $clog2(DMAX * 255 + 1);
	localparam int DW    = $clog2(2 * DMAX + 1);
	localparam int NUM_W = SUM_W + 10;
	localparam int PIX_W = 3 * CHAN_W;

	// configuration registers
	logic [RADIUS_W-1:0] radius_q;
	logic [SIZE_W-1:0]   width_q;
	logic [SIZE_W-1:0]   height_q;
	logic                cfg_acc;
	logic                restart;

	// frame position state
	logic [XW-1:0] in_col_q, emit_col_q;
	logic [YW-1:0] in_row_q, emit_row_q;
	logic [SW-1:0] in_slot_q, emit_slot_q;
	logic          complete_q;

	// window sweep state
	logic [TW-1:0]        tx_q, ty_q;
	logic signed [YSW-1:0] yraw_q;
	logic [SW-1:0]        yslot_q;
	logic                 rd_v_s1;
	logic [PIX_W-1:0]     rd_data_s1;
	logic [SUM_W-1:0]     acc_r_q, acc_g_q, acc_b_q;
	logic [DW-1:0]        den_q;

	state_t state_q, state_d;

	// memory
	logic [PIX_W-1:0] mem [DEPTH];
	logic             mem_we;
	logic [AW-1:0]    waddr, raddr;

	// effective sizes
	logic [XW-1:0]  w_eff;
	logic [YW-1:0]  h_eff;
	logic [RW-1:0]  r_eff;
	logic [TW-1:0]  r2;

	// control outputs
	logic in_acc, pix_take, out_acc, div_start, out_load, mem_re;
	logic queued;
	logic div_busy;
	logic [NUM_W-1:0] q_r, q_g, q_b;
	logic signed [XSW-1:0] xraw;
	logic [XW-1:0] xx;
	logic [XW:0] need_x;
	logic [YW:0] need_y;
	logic signed [YSW-1:0] yraw_nx, yraw0;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign restart   = cfg_acc && (cfg_index == REG_RADIUS || cfg_index == REG_WIDTH ||
		cfg_index == REG_HEIGHT);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RST_RADIUS;
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
		end else if (cfg_acc) begin
			case (cfg_index)
				REG_RADIUS: radius_q <= cfg_data[RADIUS_W-1:0];
				REG_WIDTH:  width_q  <= cfg_data[SIZE_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp register values into legal range
	always_comb begin
		if (width_q == '0) begin
			w_eff = XW'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_eff = XW'(MAX_WIDTH);
		end else begin
			w_eff = XW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = YW'(1);
		end else if (int'(height_q) > MAX_HEIGHT) begin
			h_eff = YW'(MAX_HEIGHT);
		end else begin
			h_eff = YW'(height_q);
		end
		if (int'(radius_q) > MAX_RADIUS) begin
			r_eff = RW'(MAX_RADIUS);
		end else begin
			r_eff = RW'(radius_q);
		end
		r2 = TW'({r_eff, 1'b0});
	end

	assign in_acc   = in_valid && !in_stall;
	assign pix_take = in_acc && (func == FUNC_PIXEL) && !complete_q;
	assign out_acc  = out_valid && !out_stall;

	// output queued once the lower right window corner has arrived
	always_comb begin
		need_x = ((XW+1)'(emit_col_q) + (XW+1)'(r_eff) < {1'b0, w_eff}) ?
			(XW+1)'(emit_col_q) + (XW+1)'(r_eff) : (XW+1)'(w_eff - 1'b1);
		need_y = ((YW+1)'(emit_row_q) + (YW+1)'(r_eff) < {1'b0, h_eff}) ?
			(YW+1)'(emit_row_q) + (YW+1)'(r_eff) : (YW+1)'(h_eff - 1'b1);
		queued = complete_q || (need_y < {1'b0, in_row_q}) ||
			(need_y == {1'b0, in_row_q} && need_x < {1'b0, in_col_q});
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_acc) state_d = ST_CHECK;
			ST_CHECK:  state_d = queued ? ST_READ : ST_IDLE;
			ST_READ:   if (tx_q == r2 && ty_q == r2) state_d = ST_LAST;
			ST_LAST:   state_d = ST_DSTART;
			ST_DSTART: state_d = ST_DIV;
			ST_DIV:    if (!div_busy) state_d = ST_OUT;
			ST_OUT:    if (!out_valid || !out_stall) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall  = 1'b1;
		mem_re    = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE:   in_stall  = 1'b0;
			ST_READ:   mem_re    = 1'b1;
			ST_DSTART: div_start = 1'b1;
			ST_OUT:    out_load  = !out_valid || !out_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// input and emit positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q    <= '0;
			in_row_q    <= '0;
			in_slot_q   <= '0;
			emit_col_q  <= '0;
			emit_row_q  <= '0;
			emit_slot_q <= '0;
			complete_q  <= 1'b0;
		end else if (restart) begin
			in_col_q    <= '0;
			in_row_q    <= '0;
			in_slot_q   <= '0;
			emit_col_q  <= '0;
			emit_row_q  <= '0;
			emit_slot_q <= '0;
			complete_q  <= 1'b0;
		end else begin
			if (pix_take) begin
				if (in_col_q + 1'b1 >= w_eff) begin
					in_col_q <= '0;
					if (in_row_q + 1'b1 >= h_eff) begin
						in_row_q   <= '0;
						in_slot_q  <= '0;
						complete_q <= 1'b1;
					end else begin
						in_row_q  <= in_row_q + 1'b1;
						in_slot_q <= (int'(in_slot_q) == SLOTS - 1) ? '0 : in_slot_q + 1'b1;
					end
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
			if (out_load) begin
				if (emit_col_q + 1'b1 >= w_eff) begin
					emit_col_q <= '0;
					if (emit_row_q + 1'b1 >= h_eff) begin
						emit_row_q  <= '0;
						emit_slot_q <= '0;
						complete_q  <= 1'b0;
					end else begin
						emit_row_q  <= emit_row_q + 1'b1;
						emit_slot_q <= (int'(emit_slot_q) == SLOTS - 1) ? '0 :
							emit_slot_q + 1'b1;
					end
				end else begin
					emit_col_q <= emit_col_q + 1'b1;
				end
			end
		end
	end

	// window row stepping with clamping
	always_comb begin
		yraw0   = YSW'(signed'({1'b0, emit_row_q})) - YSW'(signed'({1'b0, r_eff}));
		yraw_nx = yraw_q + YSW'(1);
		xraw    = XSW'(signed'({1'b0, emit_col_q})) - XSW'(signed'({1'b0, r_eff})) +
			XSW'(signed'({1'b0, tx_q}));
		if (xraw < 0) begin
			xx = '0;
		end else if (xraw >= XSW'(signed'({1'b0, w_eff}))) begin
			xx = w_eff - 1'b1;
		end else begin
			xx = XW'(xraw);
		end
	end

	// sweep counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_q    <= '0;
			ty_q    <= '0;
			yraw_q  <= '0;
			yslot_q <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= mem_re;
			if (state_q == ST_CHECK) begin
				tx_q   <= '0;
				ty_q   <= '0;
				yraw_q <= yraw0;
				if (yraw0 >= 0) begin
					yslot_q <= (emit_slot_q >= SW'(r_eff)) ? emit_slot_q - SW'(r_eff) :
						SW'(int'(emit_slot_q) + SLOTS - int'(r_eff));
				end else begin
					yslot_q <= '0;
				end
			end else if (mem_re) begin
				if (tx_q == r2) begin
					tx_q   <= '0;
					ty_q   <= ty_q + 1'b1;
					yraw_q <= yraw_nx;
					if (yraw_nx > 0 && yraw_nx < YSW'(signed'({1'b0, h_eff}))) begin
						yslot_q <= (int'(yslot_q) == SLOTS - 1) ? '0 : yslot_q + 1'b1;
					end
				end else begin
					tx_q <= tx_q + 1'b1;
				end
			end
		end
	end

	assign waddr  = AW'(int'(in_slot_q) * MAX_WIDTH + int'(in_col_q));
	assign raddr  = AW'(int'(yslot_q) * MAX_WIDTH + int'(xx));
	assign mem_we = pix_take;

	// row store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= {red_in, green_in, blue_in};
		end
		if (mem_re) begin
			rd_data_s1 <= mem[raddr];
		end
	end

	// window sums and divisor
	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			acc_r_q <= '0;
			acc_g_q <= '0;
			acc_b_q <= '0;
			den_q   <= DW'(2 * (2 * int'(r_eff) + 1) * (2 * int'(r_eff) + 1));
		end else if (rd_v_s1) begin
			acc_r_q <= acc_r_q + SUM_W'(rd_data_s1[3*CHAN_W-1:2*CHAN_W]);
			acc_g_q <= acc_g_q + SUM_W'(rd_data_s1[2*CHAN_W-1:CHAN_W]);
			acc_b_q <= acc_b_q + SUM_W'(rd_data_s1[CHAN_W-1:0]);
		end
	end

	// one divider per channel, numerator 512*S + D over 2*D
	bsb_div #(.NUM_W(NUM_W), .DEN_W(DW)) u_div_r (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num({1'b0, acc_r_q, 9'b0} + NUM_W'(den_q >> 1)),
		.den(den_q), .busy(div_busy), .quot(q_r)
	);
	bsb_div #(.NUM_W(NUM_W), .DEN_W(DW)) u_div_g (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num({1'b0, acc_g_q, 9'b0} + NUM_W'(den_q >> 1)),
		.den(den_q), .busy(), .quot(q_g)
	);
	bsb_div #(.NUM_W(NUM_W), .DEN_W(DW)) u_div_b (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num({1'b0, acc_b_q, 9'b0} + NUM_W'(den_q >> 1)),
		.den(den_q), .busy(), .quot(q_b)
	);

	// output register
	logic out_valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			red_out    <= q_r[OUT_CHAN_W-1:0];
			green_out  <= q_g[OUT_CHAN_W-1:0];
			blue_out   <= q_b[OUT_CHAN_W-1:0];
			out_x      <= COORD_OUT_W'(emit_col_q);
			out_y      <= COORD_OUT_W'(emit_row_q);
			frame_last <= (emit_col_q == w_eff - 1'b1) && (emit_row_q == h_eff - 1'b1);
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> sv/bsb_chk.sv
// port-level checks of the box blur, bound to the top level
module bsb_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [bsb_pkg::OUT_CHAN_W-1:0] red_out,
	input logic [bsb_pkg::COORD_OUT_W-1:0] out_x,
	input logic [bsb_pkg::COORD_OUT_W-1:0] out_y
);
	import bsb_pkg::*;

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(red_out) && $stable(out_x) &&
		$stable(out_y))
		else $error("stalled result changed");

	// one transaction at a time: busy right after an input transaction
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while busy");

	// a result appears only while the input side was busy
	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without work");

endmodule

bind separable_box_blur_clamped bsb_chk u_bsb_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .red_out(red_out),
	.out_x(out_x), .out_y(out_y)
);

>>> test/separable_box_blur_clamped_tb.sv
// testbench of the separable box blur with clamped edges: directed frames, then random frames
`timescale 1ns / 1ps

module separable_box_blur_clamped_tb;
	import bsb_pkg::*;

	localparam int SLOTS      = 2 * DEF_MAX_RADIUS + 2;
	localparam int SETTLE     = 320;
	localparam int IDLE_LIMIT = 6000;

	// index that maps to no register
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

	typedef struct packed {
		logic [OUT_CHAN_W-1:0]  r;
		logic [OUT_CHAN_W-1:0]  g;
		logic [OUT_CHAN_W-1:0]  b;
		logic [COORD_OUT_W-1:0] x;
		logic [COORD_OUT_W-1:0] y;
		logic                   last;
	} blur_px_t;

	logic clk;
	logic arst_n;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid, in_stall, func;
	logic [CHAN_W-1:0] red_in, green_in, blue_in;
	logic out_valid, out_stall;
	logic [OUT_CHAN_W-1:0] red_out, green_out, blue_out;
	logic [COORD_OUT_W-1:0] out_x, out_y;
	logic frame_last;

	separable_box_blur_clamped DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .func(func),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.out_x(out_x), .out_y(out_y), .frame_last(frame_last)
	);

	// mirror of the block state
	logic [23:0] row_store [SLOTS*DEF_MAX_WIDTH];
	int unsigned m_radius, m_width, m_height;
	int unsigned m_in_col, m_in_row, m_emit_col, m_emit_row;
	bit m_complete;
	blur_px_t blur_due[$];

	int mismatches = 0;
	int items_sent = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	bit bursty = 1;
	int stall_mode = 0;
	int stall_cnt = 0;

	// clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int unsigned eff_w();
		if (m_width == 0) return 1;
		return (m_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : m_width;
	endfunction

	function automatic int unsigned eff_h();
		if (m_height == 0) return 1;
		return (m_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : m_height;
	endfunction

	function automatic int unsigned clamp_to(int v, int unsigned size);
		if (v < 0) return 0;
		if (v >= int'(size)) return size - 1;
		return v;
	endfunction

	function automatic bit frame_busy();
		return m_in_col != 0 || m_in_row != 0 || m_emit_col != 0 || m_emit_row != 0
			|| m_complete;
	endfunction

	task automatic restart_frame();
		m_in_col = 0; m_in_row = 0; m_emit_col = 0; m_emit_row = 0; m_complete = 0;
	endtask

	// expected blur output of one accepted transaction, if any
	task automatic blur_predict(logic f, logic [7:0] rv, logic [7:0] gv, logic [7:0] bv);
		int unsigned w, h, rad, nx, ny, d, yy, xx;
		int unsigned s [3];
		logic [23:0] px;
		blur_px_t e;
		w = eff_w(); h = eff_h(); rad = m_radius;
		s[0] = 0; s[1] = 0; s[2] = 0;
		if (f == FUNC_PIXEL && !m_complete) begin
			row_store[(m_in_row % SLOTS) * DEF_MAX_WIDTH + m_in_col] = {rv, gv, bv};
			m_in_col++;
			if (m_in_col >= w) begin
				m_in_col = 0;
				m_in_row++;
				if (m_in_row >= h) begin
					m_in_row = 0;
					m_complete = 1;
				end
			end
		end
		nx = (m_emit_col + rad < w) ? m_emit_col + rad : w - 1;
		ny = (m_emit_row + rad < h) ? m_emit_row + rad : h - 1;
		if (!m_complete && ny * w + nx >= m_in_row * w + m_in_col) return;
		for (int dy = -int'(rad); dy <= int'(rad); dy++) begin
			yy = clamp_to(int'(m_emit_row) + dy, h);
			for (int dx = -int'(rad); dx <= int'(rad); dx++) begin
				xx = clamp_to(int'(m_emit_col) + dx, w);
				px = row_store[(yy % SLOTS) * DEF_MAX_WIDTH + xx];
				s[0] += px[23:16]; s[1] += px[15:8]; s[2] += px[7:0];
			end
		end
		d = (2 * rad + 1) * (2 * rad + 1);
		e.r = OUT_CHAN_W'((512 * s[0] + d) / (2 * d));
		e.g = OUT_CHAN_W'((512 * s[1] + d) / (2 * d));
		e.b = OUT_CHAN_W'((512 * s[2] + d) / (2 * d));
		e.x = COORD_OUT_W'(m_emit_col);
		e.y = COORD_OUT_W'(m_emit_row);
		e.last = (m_emit_col == w - 1 && m_emit_row == h - 1);
		blur_due.push_back(e);
		m_emit_col++;
		if (m_emit_col >= w) begin
			m_emit_col = 0;
			m_emit_row++;
			if (m_emit_row >= h) begin
				m_emit_row = 0;
				m_complete = 0;
			end
		end
	endtask

	// one input transaction, with bursts and gaps
	task automatic send_item(logic f, logic [7:0] rv, logic [7:0] gv, logic [7:0] bv);
		if (bursty && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end else if (burst_left > 0) begin
			burst_left--;
		end
		func <= f; red_in <= rv; green_in <= gv; blue_in <= bv;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		blur_predict(f, rv, gv, bv);
		items_sent++;
	endtask

	// hold the sender until every expected output is out and the block settles
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (blur_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx; cfg_data <= val; cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_RADIUS: begin m_radius = val[RADIUS_W-1:0]; restart_frame(); end
			REG_WIDTH:  begin m_width = val; restart_frame(); end
			REG_HEIGHT: begin m_height = val; restart_frame(); end
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic setup(int unsigned rad, int unsigned w, int unsigned h);
		wait_idle();
		cfg_write(REG_RADIUS, CFG_DATA_W'(rad));
		cfg_write(REG_WIDTH, CFG_DATA_W'(w));
		cfg_write(REG_HEIGHT, CFG_DATA_W'(h));
	endtask

	function automatic logic [7:0] chan(int fill);
		if (fill == 0) return 8'h00;
		if (fill == 1) return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// full frame of pixels, then drain steps until the frame is out; fill 0/1/2 = zero/max/random
	task automatic run_frame(int fill, bit noisy);
		int n;
		n = eff_w() * eff_h();
		for (int i = 0; i < n; i++) begin
			if (noisy && $urandom_range(0, 9) == 0)
				send_item(FUNC_DRAIN, chan(2), chan(2), chan(2));
			send_item(FUNC_PIXEL, chan(fill), chan(fill), chan(fill));
		end
		while (frame_busy()) begin
			if (noisy && $urandom_range(0, 4) == 0)
				send_item(FUNC_PIXEL, chan(2), chan(2), chan(2));
			else
				send_item(FUNC_DRAIN, chan(2), chan(2), chan(2));
		end
	endtask

	task automatic test_reset_defaults_small();
		// radius 5 after reset; tiny frame, drain first with nothing queued
		m_radius = RST_RADIUS; m_width = RST_WIDTH; m_height = RST_HEIGHT; restart_frame();
		cfg_write(REG_WIDTH, 11'd3);
		cfg_write(REG_HEIGHT, 11'd2);
		send_item(FUNC_DRAIN, 8'h00, 8'hFF, 8'h00);
		run_frame(2, 0);
	endtask

	task automatic test_extreme_values();
		setup(0, 2, 2);
		run_frame(0, 0);
		setup(7, 3, 3);
		run_frame(1, 0);
		setup(7, 1, 1);
		run_frame(2, 0);
	endtask

	task automatic test_out_of_range_regs();
		// width 0 acts as 1, oversize height acts as max; unused index is ignored
		setup(0, 0, 2047);
		cfg_write(REG_NONE, 11'h7FF);
		run_frame(2, 0);
		// oversize width acts as max, checked over the start of a row
		setup(1, 2047, 1);
		repeat (40) send_item(FUNC_PIXEL, chan(2), chan(2), chan(2));
	endtask

	task automatic test_tall_frame();
		setup(7, 1, 48);
		run_frame(2, 1);
	endtask

	task automatic test_restart_and_ignored_pixels();
		// partial frame then a write restarts it
		setup(2, 5, 4);
		repeat (11) send_item(FUNC_PIXEL, chan(2), chan(2), chan(2));
		wait_idle();
		cfg_write(REG_RADIUS, 11'd1);
		run_frame(2, 1);
		// back to back frames, pixels while draining are dropped
		run_frame(2, 1);
	endtask

	task automatic test_random_frames();
		int start, nw, nh;
		start = items_sent;
		while (items_sent - start < 150) begin
			bursty = ($urandom_range(0, 3) != 0);
			nw = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
			nh = $urandom_range(1, 8);
			setup($urandom_range(0, 7), nw, nh);
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(1, nw * nh)) send_item(FUNC_PIXEL, chan(2), chan(2), chan(2));
				continue;
			end
			run_frame(2, 1);
			if ($urandom_range(0, 3) == 0) run_frame(2, 1);
		end
		bursty = 1;
	endtask

	// receiver stall pattern: none, random, long holds
	always @(posedge clk) begin
		if (stall_cnt == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_cnt <= $urandom_range(16, 96);
		end else begin
			stall_cnt <= stall_cnt - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= 1'($urandom_range(0, 1));
			default: out_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// output check and watchdog
	always @(posedge clk) begin
		blur_px_t e;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: watchdog timeout", $time);
				$display("== FAIL ==");
				$finish;
			end
			if (out_valid && !out_stall) begin
				if (blur_due.size() == 0) begin
					$display("%0t: unexpected output transaction x=%0d y=%0d", $time, out_x, out_y);
					mismatches++;
				end else begin
					e = blur_due.pop_front();
					if (red_out !== e.r || green_out !== e.g || blue_out !== e.b ||
						out_x !== e.x || out_y !== e.y || frame_last !== e.last) begin
						$display("%0t: mismatch exp r=%h g=%h b=%h x=%0d y=%0d last=%b", $time,
							e.r, e.g, e.b, e.x, e.y, e.last);
						$display("%0t:          got r=%h g=%h b=%h x=%0d y=%0d last=%b", $time,
							red_out, green_out, blue_out, out_x, out_y, frame_last);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; func = FUNC_PIXEL;
		red_in = '0; green_in = '0; blue_in = '0;
		out_stall = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults_small();
		test_extreme_values();
		test_out_of_range_regs();
		test_restart_and_ignored_pixels();
		test_tall_frame();
		test_random_frames();
		wait_idle();
		if (mismatches == 0 && blur_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
